// ----- design/lspa_pkg.sv -----
// Shared types and constants for the lidar sector proximity alarm.
package lspa_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Datapath widths
  localparam int RANGE_W  = 16;
  localparam int ANGLE_W  = 18;
  localparam int MAG_W    = 15;
  localparam int SINE_W   = 16;
  localparam int OUT_W    = 24;

  // Items buffered between front and back
  localparam int QUEUE_DEPTH = 4;

  // pi/2 in Q30, and the beam angle ceiling
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic signed [ANGLE_W-1:0] ANGLE_SAT = 18'sd131071;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_ANGLE     = 3'd0,
    REG_ANGLE_STEP      = 3'd1,
    REG_END_ANGLE       = 3'd2,
    REG_FRONT_LIMIT     = 3'd3,
    REG_ROBOT_RADIUS    = 3'd4,
    REG_SECTOR_SWITCH   = 3'd5,
    REG_SIDE_ANGLE      = 3'd6,
    REG_FRONT_INDEX     = 3'd7
  } cfg_reg_t;

  // Configuration register file
  typedef struct packed {
    logic [15:0] start_angle;
    logic [12:0] angle_step;
    logic [15:0] end_angle;
    logic [15:0] front_limit_mm;
    logic [15:0] robot_radius_mm;
    logic [14:0] sector_switch_angle;
    logic [14:0] side_angle;
    logic [9:0]  front_index;
  } cfg_t;

  // start_angle resets to -18000 (two's complement)
  localparam cfg_t CFG_RESET = '{
    start_angle:         16'hB9B0,
    angle_step:          13'd36,
    end_angle:           16'd18000,
    front_limit_mm:      16'd500,
    robot_radius_mm:     16'd250,
    sector_switch_angle: 15'd2073,
    side_angle:          15'd12861,
    front_index:         10'd500
  };

  // Classified sample handed from front to back
  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic [MAG_W-1:0]   mag;
    logic               front_hit;
    logic               side_chk;
    logic               capture;
    logic               last;
  } item_t;

endpackage

// ----- design/lspa_front.sv -----
// Front part: tracks beam angle and sample index, classifies each sample.
module lspa_front #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lspa_pkg::cfg_t              cfg,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [lspa_pkg::RANGE_W-1:0] range_mm,
  input  logic                        last_sample,
  output logic                        push,
  output lspa_pkg::item_t             item
);
  import lspa_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int CMP_W = (CNT_W > 10) ? CNT_W : 10;

  logic [CNT_W-1:0]          sample_count;
  logic [CNT_W-1:0]          sample_count_next;
  logic signed [ANGLE_W-1:0] beam_angle;
  logic signed [ANGLE_W-1:0] beam_angle_next;
  logic signed [ANGLE_W-1:0] cur_angle;
  logic signed [ANGLE_W:0]   sum_angle;
  logic signed [ANGLE_W-1:0] start_s;
  logic signed [ANGLE_W-1:0] end_s;
  logic signed [ANGLE_W-1:0] sw_s;
  logic signed [ANGLE_W-1:0] sd_s;
  logic [ANGLE_W-1:0]        abs_angle;
  logic                      checked;
  logic                      in_front;
  logic                      in_side;
  logic                      at_front_index;
  logic                      count_open;

  // Widen the angle registers
  assign start_s = ANGLE_W'($signed(cfg.start_angle));
  assign end_s   = ANGLE_W'($signed(cfg.end_angle));
  assign sw_s    = $signed(ANGLE_W'(cfg.sector_switch_angle));
  assign sd_s    = $signed(ANGLE_W'(cfg.side_angle));

  // First sample of a scan sits at the start angle
  assign cur_angle = (sample_count == '0) ? start_s : beam_angle;

  // Sector classification
  assign checked  = cur_angle < end_s;
  assign in_front = (cur_angle < sw_s) && (cur_angle > -sw_s);
  assign in_side  = ((cur_angle < -sw_s) && (cur_angle > -sd_s)) ||
                    ((cur_angle > sw_s) && (cur_angle < sd_s));
  assign abs_angle = cur_angle[ANGLE_W-1] ? ANGLE_W'(-cur_angle) : ANGLE_W'(cur_angle);

  // Front distance capture point
  assign count_open     = sample_count < CNT_W'(MAX_SAMPLES);
  assign at_front_index = count_open &&
                          (CMP_W'(sample_count) == CMP_W'(cfg.front_index));

  // Advance the angle, saturating at the top
  assign sum_angle = (ANGLE_W+1)'(cur_angle) + (ANGLE_W+1)'($signed({1'b0, cfg.angle_step}));
  assign beam_angle_next = (sum_angle > (ANGLE_W+1)'(ANGLE_SAT)) ? ANGLE_SAT
                         : $signed(sum_angle[ANGLE_W-1:0]);

  always_comb begin
    if (last_sample) begin
      sample_count_next = '0;
    end else if (count_open) begin
      sample_count_next = sample_count + CNT_W'(1);
    end else begin
      sample_count_next = sample_count;
    end
  end

  // Request leaving for the queue
  assign push           = s_tvalid && s_tready;
  assign item.range_mm  = range_mm;
  assign item.mag       = abs_angle[MAG_W-1:0];
  assign item.front_hit = checked && in_front && (range_mm < cfg.front_limit_mm);
  assign item.side_chk  = checked && !in_front && in_side;
  assign item.capture   = at_front_index;
  assign item.last      = last_sample;

  // Scan position
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
    end else if (push) begin
      sample_count <= sample_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      beam_angle <= beam_angle_next;
    end
  end

endmodule

// ----- design/lspa_queue.sv -----
// Short queue of classified samples between front and back.
module lspa_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lspa_pkg::item_t item_in,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output lspa_pkg::item_t head
);
  import lspa_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full       = fill == CNT_W'(QUEUE_DEPTH);
  assign head_valid = fill != '0;
  assign head       = slots[rd_ptr];

  // Store incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- design/lspa_sine_rom.sv -----
// Quarter-wave sine ROM, Q15 magnitudes, registered read.
module lspa_sine_rom #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] addr,
  output logic [lspa_pkg::SINE_W-1:0]           data
);
  import lspa_pkg::*;

  // Unsigned quotient by shift and subtract, evaluated while the table is built
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Build entry k = sin(k * pi/2 / depth) in Q15 from an eleven-term series
  function automatic logic [(SINE_TABLE_DEPTH+1)*SINE_W-1:0] build_table();
    logic [(SINE_TABLE_DEPTH+1)*SINE_W-1:0] tbl;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    tbl = '0;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = div_u64(64'(k) * HALF_PI_Q30, 64'(SINE_TABLE_DEPTH));
      term = x;
      sum  = x;
      for (int n = 1; n <= 10; n++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = div_u64(term, 64'(2 * n) * 64'(2 * n + 1));
        if ((n % 2) == 1) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      sum = (sum + 64'd16384) >> 15;
      if (sum > 64'd32768) begin
        sum = 64'd32768;
      end
      tbl[k*SINE_W +: SINE_W] = sum[SINE_W-1:0];
    end
    return tbl;
  endfunction

  localparam logic [(SINE_TABLE_DEPTH+1)*SINE_W-1:0] SINE_TABLE = build_table();

  // Registered lookup
  always_ff @(posedge clk) begin
    if (en) begin
      data <= SINE_TABLE[addr*SINE_W +: SINE_W];
    end
  end

endmodule

// ----- design/lspa_back.sv -----
// Back part: side-sector sine check pipeline, sticky alarm and result register.
module lspa_back #(
  parameter int ANGLE_FRAC_BITS  = 13,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [15:0]                  robot_radius_mm,
  input  logic                         head_valid,
  input  lspa_pkg::item_t              head,
  output logic                         pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [lspa_pkg::OUT_W-1:0]   m_tdata
);
  import lspa_pkg::*;

  // Angle to table phase: p = (mag * SCALE) >> 16
  localparam logic [63:0] SCALE =
    (64'(SINE_TABLE_DEPTH) << (46 - ANGLE_FRAC_BITS)) / HALF_PI_Q30;
  localparam int SCALE_W = $clog2(SCALE + 1);
  localparam int PROD_W  = MAG_W + SCALE_W;
  localparam int P_W     = PROD_W - 16;
  // Quotient estimate by reciprocal, off by at most one
  localparam logic [P_W-1:0] RECIP = P_W'((64'd1 << P_W) / 64'(SINE_TABLE_DEPTH));
  localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int EXT_W   = P_W + IDX_W;

  logic               advance;
  logic               v1;
  logic               v2;
  logic               v3;
  item_t              item1;
  item_t              item2;
  item_t              item3;
  logic [PROD_W-1:0]  prod1;
  logic [P_W-1:0]     p1;
  logic [2*P_W-1:0]   prod2;
  logic [P_W-1:0]     p2;
  logic [P_W-1:0]     e2;
  logic [EXT_W-1:0]   ed;
  logic [EXT_W-1:0]   rem;
  logic [EXT_W-1:0]   rem_fixed;
  logic               fix;
  logic               odd_quad;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   rom_addr;
  logic [SINE_W-1:0]  rom_data;
  logic [31:0]        lhs;
  logic [31:0]        rhs;
  logic               side_hit;
  logic               alarm_seen;
  logic               alarm_next;
  logic [15:0]        front_range;
  logic [15:0]        front_next;
  logic               out_valid;
  logic               out_alarm;
  logic [15:0]        out_front;

  // Whole pipeline moves whenever the result register can take a value
  assign advance = !out_valid || m_tready;
  assign pop     = advance && head_valid;

  // Stage 1 input: phase multiply
  assign prod1 = PROD_W'(head.mag) * PROD_W'(SCALE[SCALE_W-1:0]);

  // Stage 2 input: quotient estimate
  assign prod2 = (2*P_W)'(p1) * (2*P_W)'(RECIP);

  // Stage 3 input: remainder, correction, quadrant fold
  assign ed        = EXT_W'(e2) * EXT_W'(SINE_TABLE_DEPTH);
  assign rem       = EXT_W'(p2) - ed;
  assign fix       = rem >= EXT_W'(SINE_TABLE_DEPTH);
  assign rem_fixed = fix ? rem - EXT_W'(SINE_TABLE_DEPTH) : rem;
  assign idx       = rem_fixed[IDX_W-1:0];
  assign odd_quad  = e2[0] ^ fix;
  assign rom_addr  = odd_quad ? IDX_W'(SINE_TABLE_DEPTH) - idx : idx;

  lspa_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_sine_rom (
    .clk  (clk),
    .en   (advance),
    .addr (rom_addr),
    .data (rom_data)
  );

  // Final: side clearance test and sticky state update
  assign lhs        = 32'(item3.range_mm) * 32'(rom_data);
  assign rhs        = {1'b0, robot_radius_mm, 15'b0};
  assign side_hit   = item3.side_chk && (lhs < rhs);
  assign alarm_next = alarm_seen || item3.front_hit || side_hit;
  assign front_next = item3.capture ? item3.range_mm : front_range;

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= head_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (advance) begin
      item1 <= head;
      p1    <= prod1[PROD_W-1:16];
      item2 <= item1;
      p2    <= p1;
      e2    <= prod2[2*P_W-1:P_W];
      item3 <= item2;
    end
  end

  // Scan state: hold alarm and front range, drop both at end of scan
  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_seen  <= 1'b0;
      front_range <= '0;
    end else if (advance && v3) begin
      alarm_seen  <= item3.last ? 1'b0 : alarm_next;
      front_range <= item3.last ? '0 : front_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= v3 && item3.last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && v3 && item3.last) begin
      out_alarm <= alarm_next;
      out_front <= front_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_W - 17)'(0), out_front, out_alarm};

endmodule

// ----- design/lidar_sector_proximity_alarm.sv -----
// Top level of the lidar sector proximity alarm.
//
//   channel  | dir | handshake           | payload
//   ---------+-----+---------------------+-----------------------------------------
//   s_*      | in  | s_tvalid / s_tready | s_tdata[15:0] range_mm, s_tlast last_sample
//   m_*      | out | m_tvalid / m_tready | m_tdata[0] alarm, [16:1] front_distance_mm
//   cfg_*    | in  | cfg_wr_en           | cfg_addr register index, cfg_wdata value
//
// One sample per cycle sustained while the result is taken; the result of a scan is
// offered once its last sample has passed the queue, the three back stages and the
// result register; the queue write lands on the accepting edge.
// The back pipeline runs as one unit, gated by the result register.
// Synchronous active-high reset; no table fill or clearing pass after reset.
// A stalled result stalls the back; the four-entry queue keeps taking samples
// until it fills.
module lidar_sector_proximity_alarm #(
  parameter int MAX_SAMPLES      = 1024,
  parameter int ANGLE_FRAC_BITS  = 13,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  // range_mm[15:0]
  input  logic [15:0]                    s_tdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic                           s_tlast,
  // alarm[0], front_distance_mm[16:1], zero pad[23:17]
  output logic [lspa_pkg::OUT_W-1:0]     m_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           cfg_wr_en,
  input  logic [lspa_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [lspa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lspa_pkg::*;

  cfg_t  cfg;
  logic  push;
  item_t front_item;
  logic  queue_full;
  logic  pop;
  logic  head_valid;
  item_t head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_START_ANGLE:   cfg.start_angle         <= cfg_wdata;
        REG_ANGLE_STEP:    cfg.angle_step          <= cfg_wdata[12:0];
        REG_END_ANGLE:     cfg.end_angle           <= cfg_wdata;
        REG_FRONT_LIMIT:   cfg.front_limit_mm      <= cfg_wdata;
        REG_ROBOT_RADIUS:  cfg.robot_radius_mm     <= cfg_wdata;
        REG_SECTOR_SWITCH: cfg.sector_switch_angle <= cfg_wdata[14:0];
        REG_SIDE_ANGLE:    cfg.side_angle          <= cfg_wdata[14:0];
        REG_FRONT_INDEX:   cfg.front_index         <= cfg_wdata[9:0];
        default:           cfg                     <= cfg;
      endcase
    end
  end

  assign s_tready = !queue_full;

  lspa_front #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .range_mm    (s_tdata),
    .last_sample (s_tlast),
    .push        (push),
    .item        (front_item)
  );

  lspa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .item_in    (front_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  lspa_back #(
    .ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .robot_radius_mm (cfg.robot_radius_mm),
    .head_valid      (head_valid),
    .head            (head),
    .pop             (pop),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata)
  );

endmodule

// ----- design/lspa_checker.sv -----
// Port-level checks for the lidar sector proximity alarm, bound to the top level.
module lspa_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       s_tlast,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [lspa_pkg::OUT_W-1:0] m_tdata
);
  import lspa_pkg::*;

  logic [7:0] scans_open;

  // Count scans whose last sample went in and whose result is not yet out
  always_ff @(posedge clk) begin
    if (rst) begin
      scans_open <= '0;
    end else begin
      case ({s_tvalid && s_tready && s_tlast, m_tvalid && m_tready})
        2'b10:   scans_open <= scans_open + 8'd1;
        2'b01:   scans_open <= scans_open - 8'd1;
        default: scans_open <= scans_open;
      endcase
    end
  end

  // Held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Padding above the front distance stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_W-1:17] == '0)
    else $error("result padding not zero");

  // No result without a finished scan behind it
  a_result_has_scan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> scans_open != 8'd0)
    else $error("result without a completed scan");

endmodule

bind lidar_sector_proximity_alarm lspa_checker u_lspa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
